/* rtl/core/jtk_pkg.sv */
// ----------------------------------------------------------------------------
// jtk_pkg
// Shared types and constants for the top-level JSON key finder.
// ----------------------------------------------------------------------------
package jtk_pkg;

   localparam int KEY_BYTES_MAX  = 32;
   localparam int OFFSET_BITS    = 16;
   localparam int DEPTH_BITS     = 8;

   localparam int KEY_REG_COUNT  = 4;
   localparam int KEY_REG_W      = 64;
   localparam int KEY_FLAT_W     = KEY_REG_COUNT * KEY_REG_W;
   localparam int KEY_LEN_W      = 6;
   localparam int KEY_INDEX_W    = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;
   localparam int VALUE_OFFSET_W = 16;

   localparam logic [OFFSET_BITS-1:0] OFFSET_TOP = '1;
   localparam logic [DEPTH_BITS-1:0]  DEPTH_TOP  = '1;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LEN   = 3'd4;

   // Characters the scanner reacts to
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_KEY   = 2'd1,
      PH_QUOTE = 2'd2,
      PH_COLON = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic                      found;
      logic [VALUE_OFFSET_W-1:0] value_offset;
   } result_type;

endpackage

/* rtl/core/json_top_level_key_finder.sv */
// ----------------------------------------------------------------------------
// json_top_level_key_finder
// Scans JSON text one byte per word and reports, once per document, where the
// value of a configured top-level key starts or that it was not found.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_stall   req_text_byte, req_end_of_text
//   rsp      out  rsp_valid / rsp_stall   rsp_found, rsp_value_offset
//   csr      in   csr_write_enable        csr_index, csr_write_data
//
// One byte per cycle sustained unless the result stalls; a byte is held in the
// input register and its result, if any, is loaded into the result register.
// The byte step is a single pass of compare and depth logic between the two.
// Reset is synchronous and clears the scan state and loads the key defaults.
// A stalled result holds the input register; req_stall rises only then.
// ----------------------------------------------------------------------------
module json_top_level_key_finder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_text_byte,
   input  logic                                  req_end_of_text,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [jtk_pkg::VALUE_OFFSET_W-1:0]    rsp_value_offset,
   input  logic                                  csr_write_enable,
   input  logic [jtk_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [jtk_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import jtk_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       result_valid;
   result_type result;
   result_type rsp_result;

   assign req_item.text_byte   = req_text_byte;
   assign req_item.end_of_text = req_end_of_text;

   jtk_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   jtk_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step             (item_valid && advance),
      .item             (item),
      .result_valid     (result_valid),
      .result           (result)
   );

   jtk_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (item_valid && advance && result_valid),
      .result     (result),
      .free       (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_found        = rsp_result.found;
   assign rsp_value_offset = rsp_result.value_offset;

endmodule

/* rtl/core/jtk_in_stage.sv */
// ----------------------------------------------------------------------------
// jtk_in_stage
// Input register: captures one text word per cycle and holds it while the
// result side is blocked.
// ----------------------------------------------------------------------------
module jtk_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  jtk_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output jtk_pkg::item_type item
);
   import jtk_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   // hold the word only when it cannot move on
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

endmodule

/* rtl/core/jtk_scan.sv */
// ----------------------------------------------------------------------------
// jtk_scan
// Key registers, document scan state and the one-byte step that tracks
// strings, depths and the key compare.
// ----------------------------------------------------------------------------
module jtk_scan (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [jtk_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [jtk_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  logic                                 step,
   input  jtk_pkg::item_type                    item,
   output logic                                 result_valid,
   output jtk_pkg::result_type                  result
);
   import jtk_pkg::*;

   logic [KEY_REG_W-1:0]   key_ff [KEY_REG_COUNT];
   logic [KEY_LEN_W-1:0]   key_len_ff;

   logic                   in_string_ff,  in_string_in;
   logic                   escape_ff,     escape_in;
   logic [DEPTH_BITS-1:0]  obj_depth_ff,  obj_depth_in;
   logic [DEPTH_BITS-1:0]  arr_depth_ff,  arr_depth_in;
   phase_type              phase_ff,      phase_in;
   logic [KEY_LEN_W-1:0]   match_idx_ff,  match_idx_in;
   logic [OFFSET_BITS-1:0] position_ff,   position_in;
   logic                   finished_ff,   finished_in;

   logic [KEY_FLAT_W-1:0]  key_flat;
   logic [KEY_LEN_W-1:0]   used_len;
   logic [7:0]             key_char;
   logic [7:0]             b;
   logic                   may_start;
   logic                   hit;
   logic                   is_space;
   logic [OFFSET_BITS-1:0] offset;

   always_comb begin
      for (int i = 0; i < KEY_REG_COUNT; i++) begin
         key_flat[i*KEY_REG_W +: KEY_REG_W] = key_ff[i];
      end
   end

   assign used_len = (key_len_ff > KEY_LEN_W'(KEY_BYTES_MAX)) ?
                     KEY_LEN_W'(KEY_BYTES_MAX) : key_len_ff;
   assign key_char = key_flat[match_idx_ff[KEY_INDEX_W-1:0]*8 +: 8];
   assign b        = item.text_byte;
   assign is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   assign offset   = (position_ff < OFFSET_TOP) ? position_ff + 1'b1 : OFFSET_TOP;

   always_comb begin
      in_string_in = in_string_ff;
      escape_in    = escape_ff;
      obj_depth_in = obj_depth_ff;
      arr_depth_in = arr_depth_ff;
      phase_in     = phase_ff;
      match_idx_in = match_idx_ff;
      finished_in  = finished_ff;
      position_in  = (position_ff < OFFSET_TOP) ? position_ff + 1'b1 : position_ff;
      may_start    = (phase_ff == PH_IDLE);
      hit          = 1'b0;
      result_valid = 1'b0;
      result       = '0;

      if (!finished_ff) begin
         if (b == CH_NUL) begin
            result_valid = 1'b1;
            finished_in  = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_KEY: begin
                  if (match_idx_ff < used_len && b == key_char) begin
                     match_idx_in = match_idx_ff + 1'b1;
                     if (match_idx_ff + 1'b1 >= used_len) begin
                        phase_in = PH_QUOTE;
                     end
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_QUOTE: begin
                  phase_in = (b == CH_QUOTE) ? PH_COLON : PH_IDLE;
               end
               PH_COLON: begin
                  if (is_space) begin
                     phase_in = PH_COLON;
                  end else if (b == CH_COLON) begin
                     result_valid        = 1'b1;
                     result.found        = 1'b1;
                     result.value_offset = VALUE_OFFSET_W'(offset);
                     finished_in         = 1'b1;
                     hit                 = 1'b1;
                  end else begin
                     // not the colon: drop the compare, the byte may start another
                     phase_in  = PH_IDLE;
                     may_start = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase

            if (!hit) begin
               if (in_string_ff) begin
                  if (!escape_ff && b == CH_BACKSLASH) begin
                     escape_in = 1'b1;
                  end else begin
                     if (!escape_ff && b == CH_QUOTE) begin
                        in_string_in = 1'b0;
                     end
                     escape_in = 1'b0;
                  end
               end else if (b == CH_QUOTE) begin
                  if (may_start && obj_depth_ff == DEPTH_BITS'(1) && arr_depth_ff == '0 &&
                      used_len != '0) begin
                     phase_in     = PH_KEY;
                     match_idx_in = '0;
                  end
                  in_string_in = 1'b1;
                  escape_in    = 1'b0;
               end else if (b == CH_LBRACE) begin
                  if (obj_depth_ff < DEPTH_TOP) obj_depth_in = obj_depth_ff + 1'b1;
               end else if (b == CH_RBRACE) begin
                  if (obj_depth_ff != '0) obj_depth_in = obj_depth_ff - 1'b1;
               end else if (b == CH_LBRACKET) begin
                  if (arr_depth_ff < DEPTH_TOP) arr_depth_in = arr_depth_ff + 1'b1;
               end else if (b == CH_RBRACKET) begin
                  if (arr_depth_ff != '0) arr_depth_in = arr_depth_ff - 1'b1;
               end
            end
         end
      end

      if (item.end_of_text) begin
         // close the document: report a miss unless already reported
         if (!finished_in && !result_valid) begin
            result_valid = 1'b1;
         end
         in_string_in = 1'b0;
         escape_in    = 1'b0;
         obj_depth_in = '0;
         arr_depth_in = '0;
         phase_in     = PH_IDLE;
         match_idx_in = '0;
         position_in  = '0;
         finished_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff <= 1'b0;
         escape_ff    <= 1'b0;
         obj_depth_ff <= '0;
         arr_depth_ff <= '0;
         phase_ff     <= PH_IDLE;
         match_idx_ff <= '0;
         position_ff  <= '0;
         finished_ff  <= 1'b0;
      end else if (step) begin
         in_string_ff <= in_string_in;
         escape_ff    <= escape_in;
         obj_depth_ff <= obj_depth_in;
         arr_depth_ff <= arr_depth_in;
         phase_ff     <= phase_in;
         match_idx_ff <= match_idx_in;
         position_ff  <= position_in;
         finished_ff  <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REG_COUNT; i++) begin
            key_ff[i] <= '0;
         end
         key_len_ff <= KEY_LEN_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_KEY_0_7:   key_ff[0]  <= csr_write_data;
            CSR_KEY_8_15:  key_ff[1]  <= csr_write_data;
            CSR_KEY_16_23: key_ff[2]  <= csr_write_data;
            CSR_KEY_24_31: key_ff[3]  <= csr_write_data;
            CSR_KEY_LEN:   key_len_ff <= csr_write_data[KEY_LEN_W-1:0];
            default:       key_len_ff <= key_len_ff;
         endcase
      end
   end

endmodule

/* rtl/core/jtk_out_stage.sv */
// ----------------------------------------------------------------------------
// jtk_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module jtk_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  jtk_pkg::result_type       result,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output jtk_pkg::result_type       rsp_result
);
   import jtk_pkg::*;

   logic       valid_ff;
   result_type result_ff;

   assign free       = !valid_ff || !rsp_stall;
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

/* rtl/core/jtk_checker.sv */
// ----------------------------------------------------------------------------
// jtk_checker
// Port-level checks for the key finder, bound to the top level.
// ----------------------------------------------------------------------------
module jtk_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_found,
   input logic [jtk_pkg::VALUE_OFFSET_W-1:0]   rsp_value_offset
);
   import jtk_pkg::*;

   // a blocked result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_value_offset))
      else $error("result word changed while stalled");

   // input backpressure only comes from a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_value_offset == '0)
      else $error("miss with nonzero offset");

   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_value_offset != '0)
      else $error("hit with zero offset");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind json_top_level_key_finder jtk_checker u_jtk_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_value_offset (rsp_value_offset)
);
